>>> rtl/blm_pkg.sv
// Package with the shared types and constants of the battery level monitor.
package blm_pkg;

  localparam int MV_W = 14;
  localparam int PIN_W = 12;
  localparam int BAND_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam int LOW_CONFIRM = 8;
  localparam int EMPTY_CONFIRM = 16;
  localparam int LOW_CNT_W = $clog2(LOW_CONFIRM + 1);
  localparam int EMPTY_CNT_W = $clog2(EMPTY_CONFIRM + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND75      = 3'd0,
    CFG_BAND50      = 3'd1,
    CFG_BAND25      = 3'd2,
    CFG_LOW_SET     = 3'd3,
    CFG_LOW_CLEAR   = 3'd4,
    CFG_EMPTY_SET   = 3'd5,
    CFG_EMPTY_CLEAR = 3'd6
  } cfg_idx_e;

  typedef enum logic [BAND_W-1:0] {
    BAND_EMPTY  = 3'd0,
    BAND_TWENTY = 3'd1,
    BAND_25     = 3'd2,
    BAND_50     = 3'd3,
    BAND_75     = 3'd4,
    BAND_FULL   = 3'd5
  } band_e;

  localparam logic [MV_W-1:0] BAND75_RST      = 14'd7900;
  localparam logic [MV_W-1:0] BAND50_RST      = 14'd7600;
  localparam logic [MV_W-1:0] BAND25_RST      = 14'd7300;
  localparam logic [MV_W-1:0] LOW_SET_RST     = 14'd7000;
  localparam logic [MV_W-1:0] LOW_CLEAR_RST   = 14'd7200;
  localparam logic [MV_W-1:0] EMPTY_SET_RST   = 14'd6300;
  localparam logic [MV_W-1:0] EMPTY_CLEAR_RST = 14'd6700;

  typedef struct packed {
    logic [MV_W-1:0] band75;
    logic [MV_W-1:0] band50;
    logic [MV_W-1:0] band25;
    logic [MV_W-1:0] low_set;
    logic [MV_W-1:0] low_clear;
    logic [MV_W-1:0] empty_set;
    logic [MV_W-1:0] empty_clear;
  } cfg_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic              low;
    logic              empty;
  } result_t;

endpackage

>>> rtl/battery_level_monitor.sv
// Top level of the battery level monitor with its sample and result registers.
//
// The sample channel takes one averaged divider pin voltage per item in
// pin_mv; an item is accepted at a clock edge with sample_valid high and
// sample_stall low. The result channel gives one item per sample with the
// display band and the debounced low and empty flags, taken at an edge with
// result_valid high and result_stall low.
// An item goes into the sample register at its accepting edge and its result
// is loaded into the result register once that register is free to take it.
// One item is taken per clock cycle while the receiver does not stall; the
// sample register and the result register form a two-entry pipeline, so a
// new sample is accepted while a result waits to be taken.
// When the receiver stalls, the result holds and the sample register fills;
// sample_stall then rises until the result is taken.
// Thresholds must be written via wr_en, wr_index and wr_data only while no
// item is in flight (not enforced here); an index beyond the list is ignored.
// Synchronous reset empties both registers, loads the default thresholds,
// clears both flags and both confirmation counters.
module battery_level_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [blm_pkg::MV_W-1:0]        wr_data,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [blm_pkg::PIN_W-1:0]       pin_mv,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [blm_pkg::BAND_W-1:0]      level_band,
  output logic                            low_flag,
  output logic                            empty_flag
);

  blm_pkg::cfg_t                 cfg;
  blm_pkg::result_t              eval_result;
  blm_pkg::result_t              result;
  logic                          stage_valid;
  logic [blm_pkg::PIN_W-1:0]     stage_pin;
  logic                          out_free;
  logic                          advance;
  logic                          sample_take;

  blm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  blm_eval u_eval (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .pin_mv (stage_pin),
    .cfg    (cfg),
    .result (eval_result)
  );

  assign out_free = !result_valid || !result_stall;
  assign advance = stage_valid && out_free;
  assign sample_stall = stage_valid && !out_free;
  assign sample_take = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (sample_take) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      stage_pin <= pin_mv;
    end
    if (advance) begin
      result <= eval_result;
    end
  end

  assign level_band = result.band;
  assign low_flag = result.low;
  assign empty_flag = result.empty;

endmodule

>>> rtl/blm_cfg_regs.sv
// Threshold register file written through the plain configuration port.
module blm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [blm_pkg::MV_W-1:0]        wr_data,
  output blm_pkg::cfg_t                   cfg
);

  blm_pkg::cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (blm_pkg::cfg_idx_e'(wr_index))
        blm_pkg::CFG_BAND75:      cfg_next.band75 = wr_data;
        blm_pkg::CFG_BAND50:      cfg_next.band50 = wr_data;
        blm_pkg::CFG_BAND25:      cfg_next.band25 = wr_data;
        blm_pkg::CFG_LOW_SET:     cfg_next.low_set = wr_data;
        blm_pkg::CFG_LOW_CLEAR:   cfg_next.low_clear = wr_data;
        blm_pkg::CFG_EMPTY_SET:   cfg_next.empty_set = wr_data;
        blm_pkg::CFG_EMPTY_CLEAR: cfg_next.empty_clear = wr_data;
        default:                  cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band75      <= blm_pkg::BAND75_RST;
      cfg.band50      <= blm_pkg::BAND50_RST;
      cfg.band25      <= blm_pkg::BAND25_RST;
      cfg.low_set     <= blm_pkg::LOW_SET_RST;
      cfg.low_clear   <= blm_pkg::LOW_CLEAR_RST;
      cfg.empty_set   <= blm_pkg::EMPTY_SET_RST;
      cfg.empty_clear <= blm_pkg::EMPTY_CLEAR_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

>>> rtl/blm_eval.sv
// Band selection and debounced low and empty flags for one sample.
module blm_eval (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [blm_pkg::PIN_W-1:0]   pin_mv,
  input  blm_pkg::cfg_t               cfg,
  output blm_pkg::result_t            result
);

  localparam logic [blm_pkg::LOW_CNT_W-1:0] LowMax =
    blm_pkg::LOW_CNT_W'(blm_pkg::LOW_CONFIRM);
  localparam logic [blm_pkg::EMPTY_CNT_W-1:0] EmptyMax =
    blm_pkg::EMPTY_CNT_W'(blm_pkg::EMPTY_CONFIRM);

  logic [blm_pkg::MV_W-1:0]        batt_mv;
  logic [blm_pkg::BAND_W-1:0]      band_sel;
  logic [blm_pkg::LOW_CNT_W-1:0]   low_count, low_count_next;
  logic [blm_pkg::EMPTY_CNT_W-1:0] empty_count, empty_count_next;
  logic                            low_state, low_state_next;
  logic                            empty_state, empty_state_next;

  // Battery voltage behind the 1/3 divider; 3 * 4095 fits in 14 bits.
  assign batt_mv = {2'b00, pin_mv} + {1'b0, pin_mv, 1'b0};

  always_comb begin
    priority if (batt_mv > cfg.band75) begin
      band_sel = blm_pkg::BAND_FULL;
    end else if (batt_mv > cfg.band50) begin
      band_sel = blm_pkg::BAND_75;
    end else if (batt_mv > cfg.band25) begin
      band_sel = blm_pkg::BAND_50;
    end else if (batt_mv > cfg.low_set) begin
      band_sel = blm_pkg::BAND_25;
    end else if (batt_mv > cfg.empty_set) begin
      band_sel = blm_pkg::BAND_TWENTY;
    end else begin
      band_sel = blm_pkg::BAND_EMPTY;
    end
  end

  always_comb begin
    low_count_next = low_count;
    low_state_next = low_state;
    priority if (batt_mv <= cfg.low_set) begin
      if (low_count < LowMax) begin
        low_count_next = low_count + 1'b1;
      end
      if (low_count_next >= LowMax) begin
        low_state_next = 1'b1;
      end
    end else if (batt_mv >= cfg.low_clear) begin
      low_count_next = '0;
      low_state_next = 1'b0;
    end else begin
      low_count_next = '0;
    end
  end

  always_comb begin
    empty_count_next = empty_count;
    empty_state_next = empty_state;
    priority if (batt_mv <= cfg.empty_set) begin
      if (empty_count < EmptyMax) begin
        empty_count_next = empty_count + 1'b1;
      end
      if (empty_count_next >= EmptyMax) begin
        empty_state_next = 1'b1;
      end
    end else if (batt_mv >= cfg.empty_clear) begin
      empty_count_next = '0;
      empty_state_next = 1'b0;
    end else begin
      empty_count_next = '0;
    end
  end

  assign result = {band_sel, low_state_next, empty_state_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      low_count <= '0;
      empty_count <= '0;
      low_state <= 1'b0;
      empty_state <= 1'b0;
    end else if (step) begin
      low_count <= low_count_next;
      empty_count <= empty_count_next;
      low_state <= low_state_next;
      empty_state <= empty_state_next;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the battery level monitor: directed and random samples.
module testbench;

  typedef logic [blm_pkg::MV_W-1:0] mv_t;
  typedef logic [blm_pkg::PIN_W-1:0] pin_t;

  localparam logic [blm_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam int MAX_IDLE = 19;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 540;
  localparam int PIN_TOP = 4095;
  localparam int MV_TOP = 16383;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          wr_en = 1'b0;
  logic [blm_pkg::CFG_IDX_W-1:0] wr_index = '0;
  logic [blm_pkg::MV_W-1:0]      wr_data = '0;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  logic [blm_pkg::PIN_W-1:0]     pin_mv = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b1;
  logic [blm_pkg::BAND_W-1:0]    level_band;
  logic                          low_flag;
  logic                          empty_flag;

  blm_pkg::cfg_t thresholds = '{blm_pkg::BAND75_RST, blm_pkg::BAND50_RST,
                                blm_pkg::BAND25_RST, blm_pkg::LOW_SET_RST,
                                blm_pkg::LOW_CLEAR_RST, blm_pkg::EMPTY_SET_RST,
                                blm_pkg::EMPTY_CLEAR_RST};
  blm_pkg::band_e band_now = blm_pkg::BAND_FULL;
  logic [7:0]     low_run = '0;
  logic [7:0]     empty_run = '0;
  logic           low_now = 1'b0;
  logic           empty_now = 1'b0;

  blm_pkg::result_t pending_levels[$];
  blm_pkg::result_t oldest_level;

  int mismatch_count = 0;
  int items_sent = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  battery_level_monitor u_top (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pin_mv       (pin_mv),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .level_band   (level_band),
    .low_flag     (low_flag),
    .empty_flag   (empty_flag)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic debounce_flag(input mv_t v, input mv_t set_mv,
                               input mv_t clr_mv, input int confirm,
                               inout logic [7:0] run, inout logic flag);
    if (v <= set_mv) begin
      if (run < confirm) run = run + 8'd1;
      if (run >= confirm) flag = 1'b1;
    end else if (v >= clr_mv) begin
      run = '0;
      flag = 1'b0;
    end else begin
      run = '0;
    end
  endtask

  task automatic predict_level(input pin_t pin);
    mv_t v;
    v = mv_t'(pin * 3);
    if (v > thresholds.band75) band_now = blm_pkg::BAND_FULL;
    else if (v > thresholds.band50) band_now = blm_pkg::BAND_75;
    else if (v > thresholds.band25) band_now = blm_pkg::BAND_50;
    else if (v > thresholds.low_set) band_now = blm_pkg::BAND_25;
    else if (v > thresholds.empty_set) band_now = blm_pkg::BAND_TWENTY;
    else band_now = blm_pkg::BAND_EMPTY;
    debounce_flag(v, thresholds.low_set, thresholds.low_clear, blm_pkg::LOW_CONFIRM,
                  low_run, low_now);
    debounce_flag(v, thresholds.empty_set, thresholds.empty_clear,
                  blm_pkg::EMPTY_CONFIRM, empty_run, empty_now);
    pending_levels.push_back('{band: band_now, low: low_now, empty: empty_now});
  endtask

  task automatic write_threshold(input logic [blm_pkg::CFG_IDX_W-1:0] idx,
                                 input mv_t value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      blm_pkg::CFG_BAND75:      thresholds.band75 = value;
      blm_pkg::CFG_BAND50:      thresholds.band50 = value;
      blm_pkg::CFG_BAND25:      thresholds.band25 = value;
      blm_pkg::CFG_LOW_SET:     thresholds.low_set = value;
      blm_pkg::CFG_LOW_CLEAR:   thresholds.low_clear = value;
      blm_pkg::CFG_EMPTY_SET:   thresholds.empty_set = value;
      blm_pkg::CFG_EMPTY_CLEAR: thresholds.empty_clear = value;
      default: ;
    endcase
  endtask

  task automatic write_all_thresholds(input blm_pkg::cfg_t c);
    write_threshold(blm_pkg::CFG_BAND75, c.band75);
    write_threshold(blm_pkg::CFG_BAND50, c.band50);
    write_threshold(blm_pkg::CFG_BAND25, c.band25);
    write_threshold(blm_pkg::CFG_LOW_SET, c.low_set);
    write_threshold(blm_pkg::CFG_LOW_CLEAR, c.low_clear);
    write_threshold(blm_pkg::CFG_EMPTY_SET, c.empty_set);
    write_threshold(blm_pkg::CFG_EMPTY_CLEAR, c.empty_clear);
  endtask

  task automatic send_sample(input pin_t pin);
    int gap;
    gap = send_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    pin_mv <= pin;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predict_level(pin);
    items_sent++;
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd2400);
    send_sample(12'd2100);
  endtask

  task automatic test_band_chain();
    send_sample(12'd2700);
    send_sample(12'd2600);
    send_sample(12'd2500);
    send_sample(12'd2380);
  endtask

  // Holds the pin at zero long enough to confirm both flags and saturate both
  // counters, then steps into the empty hysteresis band and back out to full.
  task automatic test_flag_confirm();
    repeat (blm_pkg::EMPTY_CONFIRM + 1) send_sample(12'd0);
    send_sample(12'd2200);
    send_sample(12'd4095);
  endtask

  // Writes to the unused index, thresholds out of order, and clear levels at
  // or below the set levels.
  task automatic test_odd_config();
    drain_results();
    write_threshold(CFG_SPARE_IDX, mv_t'($urandom_range(0, MV_TOP)));
    write_all_thresholds('{mv_t'(0), mv_t'(MV_TOP), mv_t'(MV_TOP), mv_t'(MV_TOP),
                           mv_t'(0), mv_t'(MV_TOP), mv_t'(0)});
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1);
  endtask

  task automatic test_random_sequences();
    blm_pkg::cfg_t c;
    int stop_at;
    int phase_end;
    int region;
    int lo;
    int hi;
    int t;
    int pin;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      drain_results();
      case ($urandom_range(0, 3))
        0: c = '{blm_pkg::BAND75_RST, blm_pkg::BAND50_RST, blm_pkg::BAND25_RST,
                 blm_pkg::LOW_SET_RST, blm_pkg::LOW_CLEAR_RST,
                 blm_pkg::EMPTY_SET_RST, blm_pkg::EMPTY_CLEAR_RST};
        1: begin
          c.empty_set = mv_t'($urandom_range(0, 9000));
          c.empty_clear = mv_t'(c.empty_set + $urandom_range(0, 600));
          c.low_set = mv_t'(c.empty_set + $urandom_range(0, 1500));
          c.low_clear = mv_t'(c.low_set + $urandom_range(0, 600));
          c.band25 = mv_t'(c.low_set + $urandom_range(0, 900));
          c.band50 = mv_t'(c.band25 + $urandom_range(0, 900));
          c.band75 = mv_t'(c.band50 + $urandom_range(0, 900));
        end
        2: begin
          c.band75 = mv_t'($urandom_range(0, MV_TOP));
          c.band50 = mv_t'($urandom_range(0, MV_TOP));
          c.band25 = mv_t'($urandom_range(0, MV_TOP));
          c.low_set = mv_t'($urandom_range(0, MV_TOP));
          c.low_clear = mv_t'($urandom_range(0, MV_TOP));
          c.empty_set = mv_t'($urandom_range(0, MV_TOP));
          c.empty_clear = mv_t'($urandom_range(0, MV_TOP));
        end
        default: begin
          c.band75 = mv_t'($urandom_range(0, 1) ? MV_TOP : 0);
          c.band50 = mv_t'($urandom_range(0, 1) ? MV_TOP : 0);
          c.band25 = mv_t'($urandom_range(0, 1) ? MV_TOP : 0);
          c.low_set = mv_t'($urandom_range(0, 1) ? MV_TOP : 0);
          c.low_clear = mv_t'($urandom_range(0, 1) ? MV_TOP : 0);
          c.empty_set = mv_t'($urandom_range(0, 1) ? MV_TOP : 0);
          c.empty_clear = mv_t'($urandom_range(0, 1) ? MV_TOP : 0);
        end
      endcase
      write_all_thresholds(c);
      if ($urandom_range(0, 3) == 0) begin
        write_threshold(CFG_SPARE_IDX, mv_t'($urandom_range(0, MV_TOP)));
      end
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      phase_end = items_sent + int'($urandom_range(30, 70));
      while (items_sent < phase_end) begin
        region = int'($urandom_range(0, 7));
        repeat ($urandom_range(1, 24)) begin
          pin = int'($urandom_range(0, PIN_TOP));
          case (region)
            1, 2: begin
              hi = int'(thresholds.low_set) / 3;
              if (hi > PIN_TOP) hi = PIN_TOP;
              pin = int'($urandom_range(0, hi));
            end
            3, 4: begin
              hi = int'(thresholds.empty_set) / 3;
              if (hi > PIN_TOP) hi = PIN_TOP;
              pin = int'($urandom_range(0, hi));
            end
            5: begin
              case ($urandom_range(0, 6))
                0: t = int'(thresholds.band75);
                1: t = int'(thresholds.band50);
                2: t = int'(thresholds.band25);
                3: t = int'(thresholds.low_set);
                4: t = int'(thresholds.low_clear);
                5: t = int'(thresholds.empty_set);
                default: t = int'(thresholds.empty_clear);
              endcase
              pin = t / 3 + int'($urandom_range(0, 2)) - 1;
              if (pin < 0) pin = 0;
              if (pin > PIN_TOP) pin = PIN_TOP;
            end
            6: begin
              if ($urandom_range(0, 1)) begin
                lo = int'(thresholds.low_set) / 3 + 1;
                hi = (int'(thresholds.low_clear) - 1) / 3;
              end else begin
                lo = int'(thresholds.empty_set) / 3 + 1;
                hi = (int'(thresholds.empty_clear) - 1) / 3;
              end
              if (hi > PIN_TOP) hi = PIN_TOP;
              if (thresholds.low_clear != 0 && lo <= hi) pin = int'($urandom_range(lo, hi));
            end
            7: begin
              t = (thresholds.low_clear > thresholds.empty_clear) ?
                  int'(thresholds.low_clear) : int'(thresholds.empty_clear);
              lo = (t + 2) / 3;
              if (lo <= PIN_TOP) pin = int'($urandom_range(lo, PIN_TOP));
            end
            default: ;
          endcase
          if ($urandom_range(0, 9) == 0) pin = int'($urandom_range(0, PIN_TOP));
          send_sample(pin_t'(pin));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (result_valid && !result_stall) begin
      stall_left = recv_idle ? int'($urandom_range(0, MAX_IDLE)) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    result_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("result item with none expected", 32'(level_band), 32'd0);
      end else begin
        oldest_level = pending_levels.pop_front();
        if (level_band !== oldest_level.band)
          report_mismatch("level_band", 32'(level_band), 32'(oldest_level.band));
        if (low_flag !== oldest_level.low)
          report_mismatch("low_flag", 32'(low_flag), 32'(oldest_level.low));
        if (empty_flag !== oldest_level.empty)
          report_mismatch("empty_flag", 32'(empty_flag), 32'(oldest_level.empty));
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_band_chain();
    test_flag_confirm();
    test_odd_config();
    test_random_sequences();
    drain_results();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
